// ===== hw/rtl/lot_pkg.sv =====
// ----------------------------------------------------------------------------
// lot_pkg: shared types, constants and control store
// Request codes, control word layout, interface structs and the step program
// that drives the linked order table datapath.
// ----------------------------------------------------------------------------
package lot_pkg;

  localparam int REQ_W         = 3;
  localparam int ITEM_W        = 11;
  localparam int SUM_W         = 20;
  localparam int UPC_W         = 6;
  localparam int LOT_MAX_ITEMS = 1024;

  localparam logic [SUM_W-1:0]  SUM_MAX         = {SUM_W{1'b1}};
  localparam logic [ITEM_W-1:0] CFG_COUNT_RESET = 11'd1024;

  typedef enum logic [REQ_W-1:0] {
    REQ_INIT    = 3'd0,
    REQ_BEFORE  = 3'd1,
    REQ_AFTER   = 3'd2,
    REQ_SWAP    = 3'd3,
    REQ_REVERSE = 3'd4,
    REQ_QUERY   = 3'd5
  } req_t;

  // operand selects for read address, write address and write data
  typedef enum logic [3:0] {
    SEL_ZERO,
    SEL_X,
    SEL_Y,
    SEL_PX,
    SEL_NX,
    SEL_PY,
    SEL_NY,
    SEL_IDX,
    SEL_IDX_M1,
    SEL_IDX_P1,
    SEL_LEN,
    SEL_CUR
  } sel_t;

  typedef enum logic [1:0] {
    CAP_NONE,
    CAP_X,
    CAP_Y
  } cap_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_INIT_SETUP,
    OP_IDX_INC,
    OP_REV_TOGGLE,
    OP_QUERY_SETUP,
    OP_CUR_IDX,
    OP_ACCUM,
    OP_CUR_FWD,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_PREVQ_EQ_X,
    C_NEXTQ_EQ_X,
    C_NEXTQ_EQ_Y,
    C_IDX_NE_LEN,
    C_BACKQ_ZERO,
    C_WALK_MORE
  } cond_t;

  typedef logic [UPC_W-1:0] upc_t;

  typedef struct packed {
    logic  rd_en;
    sel_t  rd_sel;
    cap_t  cap;
    logic  wp_en;
    sel_t  wp_addr;
    sel_t  wp_data;
    logic  wn_en;
    sel_t  wn_addr;
    sel_t  wn_data;
    op_t   op;
    cond_t cond;
    upc_t  target;
    logic  last;
  } uword_t;

  typedef struct packed {
    logic   take;
    logic   fire;
    uword_t uw;
  } lot_ctl_t;

  typedef struct packed {
    logic prevq_eq_x;
    logic nextq_eq_x;
    logic nextq_eq_y;
    logic idx_ne_len;
    logic backq_zero;
    logic walk_more;
    logic out_busy;
    logic args_ok;
    logic rev;
  } lot_stat_t;

  // program entry points
  localparam upc_t UA_INIT     = 6'd0;
  localparam upc_t UA_INIT_LP  = 6'd1;
  localparam upc_t UA_REV      = 6'd3;
  localparam upc_t UA_BEFORE   = 6'd4;
  localparam upc_t UA_AFTER    = 6'd12;
  localparam upc_t UA_SWAP     = 6'd20;
  localparam upc_t UA_ADJ_XY   = 6'd27;
  localparam upc_t UA_ADJ_YX   = 6'd30;
  localparam upc_t UA_QUERY    = 6'd33;
  localparam upc_t UA_SCAN     = 6'd34;
  localparam upc_t UA_WALK     = 6'd38;
  localparam upc_t UA_DONE     = 6'd41;
  localparam upc_t UA_LAST     = 6'd41;

  localparam uword_t UW_NOP = '{
    rd_en:   1'b0, rd_sel:  SEL_ZERO, cap: CAP_NONE,
    wp_en:   1'b0, wp_addr: SEL_ZERO, wp_data: SEL_ZERO,
    wn_en:   1'b0, wn_addr: SEL_ZERO, wn_data: SEL_ZERO,
    op:      OP_NONE, cond: C_NEVER, target: '0, last: 1'b0
  };

  function automatic uword_t f_rd(input uword_t w, input sel_t s);
    uword_t r;
    r = w;
    r.rd_en  = 1'b1;
    r.rd_sel = s;
    return r;
  endfunction

  function automatic uword_t f_cap(input uword_t w, input cap_t c);
    uword_t r;
    r = w;
    r.cap = c;
    return r;
  endfunction

  function automatic uword_t f_wp(input uword_t w, input sel_t a, input sel_t d);
    uword_t r;
    r = w;
    r.wp_en   = 1'b1;
    r.wp_addr = a;
    r.wp_data = d;
    return r;
  endfunction

  function automatic uword_t f_wn(input uword_t w, input sel_t a, input sel_t d);
    uword_t r;
    r = w;
    r.wn_en   = 1'b1;
    r.wn_addr = a;
    r.wn_data = d;
    return r;
  endfunction

  function automatic uword_t f_op(input uword_t w, input op_t o);
    uword_t r;
    r = w;
    r.op = o;
    return r;
  endfunction

  function automatic uword_t f_br(input uword_t w, input cond_t c, input upc_t t);
    uword_t r;
    r = w;
    r.cond   = c;
    r.target = t;
    return r;
  endfunction

  function automatic uword_t f_end(input uword_t w);
    uword_t r;
    r = w;
    r.last = 1'b1;
    return r;
  endfunction

  // control store: link read data of a step is registered and seen by the step after it
  function automatic uword_t lot_ucode(input upc_t a);
    uword_t w;
    w = f_end(UW_NOP);
    unique case (a)
      // init: write 1..n as a chain, then close the tail
      UA_INIT:          w = f_op(UW_NOP, OP_INIT_SETUP);
      UA_INIT_LP:       w = f_br(f_op(f_wn(f_wp(UW_NOP, SEL_IDX, SEL_IDX_M1),
                                           SEL_IDX, SEL_IDX_P1), OP_IDX_INC),
                             C_IDX_NE_LEN, UA_INIT_LP);
      UA_INIT + 6'd2:   w = f_end(f_wn(UW_NOP, SEL_LEN, SEL_ZERO));
      UA_REV:           w = f_end(f_op(UW_NOP, OP_REV_TOGGLE));
      // move x before y
      UA_BEFORE:        w = f_rd(UW_NOP, SEL_Y);
      UA_BEFORE + 6'd1: w = f_br(f_rd(UW_NOP, SEL_X), C_PREVQ_EQ_X, UA_DONE);
      UA_BEFORE + 6'd2: w = f_cap(UW_NOP, CAP_X);
      UA_BEFORE + 6'd3: w = f_wp(f_wn(UW_NOP, SEL_PX, SEL_NX), SEL_NX, SEL_PX);
      UA_BEFORE + 6'd4: w = f_rd(UW_NOP, SEL_Y);
      UA_BEFORE + 6'd5: w = f_cap(UW_NOP, CAP_Y);
      UA_BEFORE + 6'd6: w = f_wp(f_wn(UW_NOP, SEL_PY, SEL_X), SEL_X, SEL_PY);
      UA_BEFORE + 6'd7: w = f_end(f_wp(f_wn(UW_NOP, SEL_X, SEL_Y), SEL_Y, SEL_X));
      // move x after y
      UA_AFTER:         w = f_rd(UW_NOP, SEL_Y);
      UA_AFTER + 6'd1:  w = f_br(f_rd(UW_NOP, SEL_X), C_NEXTQ_EQ_X, UA_DONE);
      UA_AFTER + 6'd2:  w = f_cap(UW_NOP, CAP_X);
      UA_AFTER + 6'd3:  w = f_wp(f_wn(UW_NOP, SEL_PX, SEL_NX), SEL_NX, SEL_PX);
      UA_AFTER + 6'd4:  w = f_rd(UW_NOP, SEL_Y);
      UA_AFTER + 6'd5:  w = f_cap(UW_NOP, CAP_Y);
      UA_AFTER + 6'd6:  w = f_wn(f_wp(UW_NOP, SEL_NY, SEL_X), SEL_X, SEL_NY);
      UA_AFTER + 6'd7:  w = f_end(f_wn(f_wp(UW_NOP, SEL_X, SEL_Y), SEL_Y, SEL_X));
      // swap, with the two adjacent orders split off
      UA_SWAP:          w = f_rd(UW_NOP, SEL_X);
      UA_SWAP + 6'd1:   w = f_br(f_cap(f_rd(UW_NOP, SEL_Y), CAP_X), C_NEXTQ_EQ_Y,
                             UA_ADJ_XY);
      UA_SWAP + 6'd2:   w = f_br(f_cap(UW_NOP, CAP_Y), C_NEXTQ_EQ_X, UA_ADJ_YX);
      UA_SWAP + 6'd3:   w = f_wp(f_wn(UW_NOP, SEL_PX, SEL_Y), SEL_NX, SEL_Y);
      UA_SWAP + 6'd4:   w = f_wp(f_wn(UW_NOP, SEL_PY, SEL_X), SEL_NY, SEL_X);
      UA_SWAP + 6'd5:   w = f_wp(f_wn(UW_NOP, SEL_Y, SEL_NX), SEL_Y, SEL_PX);
      UA_SWAP + 6'd6:   w = f_end(f_wp(f_wn(UW_NOP, SEL_X, SEL_NY), SEL_X, SEL_PY));
      UA_ADJ_XY:        w = f_cap(f_wp(f_wn(UW_NOP, SEL_PX, SEL_Y), SEL_Y, SEL_PX),
                              CAP_Y);
      UA_ADJ_XY + 6'd1: w = f_wp(f_wn(UW_NOP, SEL_X, SEL_NY), SEL_NY, SEL_X);
      UA_ADJ_XY + 6'd2: w = f_end(f_wp(f_wn(UW_NOP, SEL_Y, SEL_X), SEL_X, SEL_Y));
      UA_ADJ_YX:        w = f_wp(f_wn(UW_NOP, SEL_PY, SEL_X), SEL_X, SEL_PY);
      UA_ADJ_YX + 6'd1: w = f_wp(f_wn(UW_NOP, SEL_Y, SEL_NX), SEL_NX, SEL_Y);
      UA_ADJ_YX + 6'd2: w = f_end(f_wp(f_wn(UW_NOP, SEL_X, SEL_Y), SEL_Y, SEL_X));
      // query: head scan, then walk
      UA_QUERY:         w = f_op(UW_NOP, OP_QUERY_SETUP);
      UA_SCAN:          w = f_rd(UW_NOP, SEL_IDX);
      UA_SCAN + 6'd1:   w = f_br(f_op(UW_NOP, OP_CUR_IDX), C_BACKQ_ZERO, UA_WALK);
      UA_SCAN + 6'd2:   w = f_br(f_op(UW_NOP, OP_IDX_INC), C_IDX_NE_LEN, UA_SCAN);
      UA_SCAN + 6'd3:   w = f_end(f_op(UW_NOP, OP_EMIT));
      UA_WALK:          w = f_op(f_rd(UW_NOP, SEL_CUR), OP_ACCUM);
      UA_WALK + 6'd1:   w = f_br(f_op(UW_NOP, OP_CUR_FWD), C_WALK_MORE, UA_WALK);
      UA_WALK + 6'd2:   w = f_end(f_op(UW_NOP, OP_EMIT));
      UA_DONE:          w = f_end(UW_NOP);
      default:          w = f_end(UW_NOP);
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/linked_order_table_core.sv =====
// ----------------------------------------------------------------------------
// linked_order_table_core: ordering of items kept as a doubly linked list
// Requests in on a valid/ready channel, query sums out on another, and a
// write-only item_count register on its own valid/ready channel.
// ----------------------------------------------------------------------------
// Usage:
//   Send init first; it rebuilds the order 1..n (n = item_count clamped to
//   1..MAX_ITEMS) and clears the reverse flag. item_count is always ready
//   and is used at the next init. One request is worked at a time; in_ready
//   is high whenever no program runs.
// Each request runs as a program of link access steps, one per cycle unless
//   an emit step waits on a busy result register; both link memories are
//   read at one address with registered data. An ignored request starts no
//   program, a move stops early when already in place, swap has steps of its
//   own for adjacent orders, and query finds the head, then walks the list.
// Only query gives a transaction on the result channel. The result sits in
//   an output register; a new request is accepted while it waits. If the
//   receiver stalls when the next query finishes, that query holds in its
//   last step until the register frees.
// Reset clears the reverse flag, the list length and out_valid, and sets
//   item_count to 1024; link memory content is undefined until init.
// ----------------------------------------------------------------------------
module linked_order_table_core #(
  parameter int MAX_ITEMS = lot_pkg::LOT_MAX_ITEMS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lot_pkg::ITEM_W-1:0] item_count,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [lot_pkg::REQ_W-1:0]  req_type,
  input  logic [lot_pkg::ITEM_W-1:0] first_item,
  input  logic [lot_pkg::ITEM_W-1:0] second_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [lot_pkg::SUM_W-1:0]  odd_position_sum
);
  import lot_pkg::*;

  lot_ctl_t  ctl;
  lot_stat_t stat;

  lot_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (req_type),
    .stat     (stat),
    .ctl      (ctl)
  );

  lot_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .ctl              (ctl),
    .stat             (stat),
    .first_item       (first_item),
    .second_item      (second_item),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .item_count       (item_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .odd_position_sum (odd_position_sum)
  );

endmodule

// ===== hw/rtl/lot_sequencer.sv =====
// ----------------------------------------------------------------------------
// lot_sequencer: step counter and control store
// Picks a program entry per request, steps through the control words and
// takes conditional jumps on datapath status.
// ----------------------------------------------------------------------------
module lot_sequencer (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [lot_pkg::REQ_W-1:0] req_type,
  input  lot_pkg::lot_stat_t        stat,
  output lot_pkg::lot_ctl_t         ctl
);
  import lot_pkg::*;

  logic   active;
  upc_t   pc;
  uword_t uw;
  logic   take;
  logic   start;
  upc_t   entry;
  logic   hit;
  logic   stall;
  logic   fire;

  assign in_ready = !active;
  assign take     = in_valid && in_ready;
  assign uw       = lot_ucode(pc);
  assign stall    = (uw.op == OP_EMIT) && stat.out_busy;
  assign fire     = active && !stall;
  assign ctl      = '{take: take, fire: fire, uw: uw};

  // ignored requests never start a program
  always_comb begin
    start = 1'b0;
    entry = UA_DONE;
    unique case (req_type)
      REQ_INIT: begin
        start = 1'b1;
        entry = UA_INIT;
      end
      REQ_BEFORE: begin
        start = stat.args_ok;
        entry = stat.rev ? UA_AFTER : UA_BEFORE;
      end
      REQ_AFTER: begin
        start = stat.args_ok;
        entry = stat.rev ? UA_BEFORE : UA_AFTER;
      end
      REQ_SWAP: begin
        start = stat.args_ok;
        entry = UA_SWAP;
      end
      REQ_REVERSE: begin
        start = 1'b1;
        entry = UA_REV;
      end
      REQ_QUERY: begin
        start = 1'b1;
        entry = UA_QUERY;
      end
      default: begin
        start = 1'b0;
        entry = UA_DONE;
      end
    endcase
  end

  always_comb begin
    unique case (uw.cond)
      C_NEVER:      hit = 1'b0;
      C_PREVQ_EQ_X: hit = stat.prevq_eq_x;
      C_NEXTQ_EQ_X: hit = stat.nextq_eq_x;
      C_NEXTQ_EQ_Y: hit = stat.nextq_eq_y;
      C_IDX_NE_LEN: hit = stat.idx_ne_len;
      C_BACKQ_ZERO: hit = stat.backq_zero;
      C_WALK_MORE:  hit = stat.walk_more;
      default:      hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      pc     <= UA_DONE;
    end else if (take && start) begin
      active <= 1'b1;
      pc     <= entry;
    end else if (fire) begin
      if (hit) begin
        pc <= uw.target;
      end else if (uw.last) begin
        active <= 1'b0;
      end else begin
        pc <= pc + 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_start_entry: assert property (@(posedge clk) disable iff (rst)
    take && start |=> active && (pc == $past(entry)))
    else $error("program did not start at its entry");

  a_last_step_idle: assert property (@(posedge clk) disable iff (rst)
    fire && uw.last && !hit |=> !active)
    else $error("sequencer still busy after final step");

  a_pc_in_program: assert property (@(posedge clk) disable iff (rst)
    active |-> (pc <= UA_LAST))
    else $error("step counter left the program");
`endif

endmodule

// ===== hw/rtl/lot_datapath.sv =====
// ----------------------------------------------------------------------------
// lot_datapath: link memories, working registers and result register
// Executes one control word per cycle, save emit stalls: one read of both link
// memories, one write each, operand latches, scan/walk counts, saturating sum.
// ----------------------------------------------------------------------------
module lot_datapath #(
  parameter int MAX_ITEMS = lot_pkg::LOT_MAX_ITEMS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  lot_pkg::lot_ctl_t          ctl,
  output lot_pkg::lot_stat_t         stat,
  input  logic [lot_pkg::ITEM_W-1:0] first_item,
  input  logic [lot_pkg::ITEM_W-1:0] second_item,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lot_pkg::ITEM_W-1:0] item_count,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [lot_pkg::SUM_W-1:0]  odd_position_sum
);
  import lot_pkg::*;

  localparam int IW    = $clog2(MAX_ITEMS + 1);
  localparam int CW    = (IW > ITEM_W) ? IW : ITEM_W;
  localparam int DEPTH = MAX_ITEMS + 1;

  typedef logic [IW-1:0] link_t;

  link_t prev_mem [DEPTH];
  link_t next_mem [DEPTH];

  link_t prev_q;
  link_t next_q;
  link_t x_item;
  link_t y_item;
  link_t px;
  link_t nx;
  link_t py;
  link_t ny;
  link_t idx;
  link_t cur;
  link_t steps;
  link_t list_len;
  logic  rev;
  logic [ITEM_W-1:0] cfg_count;
  logic [SUM_W-1:0]  sum;

  link_t rd_addr;
  link_t wp_addr;
  link_t wp_data;
  link_t wn_addr;
  link_t wn_data;
  link_t back_q;
  link_t fwd_q;
  logic [CW-1:0] cnt_w;
  logic [CW-1:0] max_w;
  logic [CW-1:0] clamp_w;
  logic [CW-1:0] x_w;
  logic [CW-1:0] y_w;
  logic [CW-1:0] len_w;
  logic [SUM_W:0] acc;
  logic [SUM_W-1:0] sum_sat;
  logic fire;

  function automatic link_t pick(input sel_t s);
    unique case (s)
      SEL_ZERO:   return '0;
      SEL_X:      return x_item;
      SEL_Y:      return y_item;
      SEL_PX:     return px;
      SEL_NX:     return nx;
      SEL_PY:     return py;
      SEL_NY:     return ny;
      SEL_IDX:    return idx;
      SEL_IDX_M1: return idx - 1'b1;
      SEL_IDX_P1: return idx + 1'b1;
      SEL_LEN:    return list_len;
      SEL_CUR:    return cur;
      default:    return '0;
    endcase
  endfunction

  assign fire    = ctl.fire;
  assign rd_addr = pick(ctl.uw.rd_sel);
  assign wp_addr = pick(ctl.uw.wp_addr);
  assign wp_data = pick(ctl.uw.wp_data);
  assign wn_addr = pick(ctl.uw.wn_addr);
  assign wn_data = pick(ctl.uw.wn_data);

  // reverse flag swaps which link points toward the head
  assign back_q = rev ? next_q : prev_q;
  assign fwd_q  = rev ? prev_q : next_q;

  assign cnt_w   = CW'(cfg_count);
  assign max_w   = CW'(MAX_ITEMS);
  assign clamp_w = (cnt_w == '0) ? CW'(1) : ((cnt_w > max_w) ? max_w : cnt_w);

  assign x_w   = CW'(first_item);
  assign y_w   = CW'(second_item);
  assign len_w = CW'(list_len);

  assign acc     = {1'b0, sum} + (SUM_W + 1)'(cur);
  assign sum_sat = acc[SUM_W] ? SUM_MAX : acc[SUM_W-1:0];

  assign cfg_ready = 1'b1;

  assign stat = '{
    prevq_eq_x: (prev_q == x_item),
    nextq_eq_x: (next_q == x_item),
    nextq_eq_y: (next_q == y_item),
    idx_ne_len: (idx != list_len),
    backq_zero: (back_q == '0),
    walk_more:  (fwd_q != '0) && (steps != list_len),
    out_busy:   out_valid && !out_ready,
    args_ok:    (x_w != '0) && (y_w != '0) && (x_w <= len_w) && (y_w <= len_w)
                && (x_w != y_w),
    rev:        rev
  };

  // link memories, registered read of both at one address
  always_ff @(posedge clk) begin
    if (fire && ctl.uw.wp_en) begin
      prev_mem[wp_addr] <= wp_data;
    end
    if (fire && ctl.uw.wn_en) begin
      next_mem[wn_addr] <= wn_data;
    end
    if (fire && ctl.uw.rd_en) begin
      prev_q <= prev_mem[rd_addr];
      next_q <= next_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rev       <= 1'b0;
      list_len  <= '0;
      out_valid <= 1'b0;
      cfg_count <= CFG_COUNT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_count <= item_count;
      end
      if (fire && (ctl.uw.op == OP_INIT_SETUP)) begin
        list_len <= IW'(clamp_w);
        rev      <= 1'b0;
      end
      if (fire && (ctl.uw.op == OP_REV_TOGGLE)) begin
        rev <= !rev;
      end
      if (fire && (ctl.uw.op == OP_EMIT)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      x_item <= IW'(first_item);
      y_item <= IW'(second_item);
    end
    if (fire) begin
      unique case (ctl.uw.cap)
        CAP_X: begin
          px <= prev_q;
          nx <= next_q;
        end
        CAP_Y: begin
          py <= prev_q;
          ny <= next_q;
        end
        default: begin
        end
      endcase
      unique case (ctl.uw.op)
        OP_INIT_SETUP:  idx <= IW'(1);
        OP_IDX_INC:     idx <= idx + 1'b1;
        OP_QUERY_SETUP: begin
          idx   <= IW'(1);
          sum   <= '0;
          steps <= '0;
        end
        OP_CUR_IDX:     cur <= idx;
        OP_ACCUM: begin
          // only even step counts land on odd positions
          if (!steps[0]) begin
            sum <= sum_sat;
          end
          steps <= steps + 1'b1;
        end
        OP_CUR_FWD:     cur <= fwd_q;
        OP_EMIT:        odd_position_sum <= sum;
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTH
  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    fire && (ctl.uw.op == OP_EMIT) |=> out_valid && (odd_position_sum == $past(sum)))
    else $error("result not loaded on emit");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    CW'(list_len) <= max_w)
    else $error("list length above table size");

  a_rev_toggles: assert property (@(posedge clk) disable iff (rst)
    fire && (ctl.uw.op == OP_REV_TOGGLE) |=> (rev != $past(rev)))
    else $error("reverse flag did not toggle");
`endif

endmodule
